// ----- rtl/core/spv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package spv_pkg;
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_END    = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;
    localparam logic [2:0] REG_FADE   = 3'd5;

    localparam int POS_W = 50;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        load_address;
        logic signed [15:0] load_value;
        logic signed [31:0] mix_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mix_out;
        logic               voice_active;
        logic [17:0]        loudness;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } cfg_item_t;
endpackage
`default_nettype wire

// ----- rtl/core/spv_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface spv_in_if;
    logic valid;
    logic ready;
    spv_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spv_out_if;
    logic valid;
    logic ready;
    spv_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spv_cfg_if;
    logic valid;
    logic ready;
    spv_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/spv_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module spv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/spv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module spv_div #(
    parameter int NW = 53,
    parameter int DW = 35
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   sh;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        sh = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (sh >= {1'b0, d_reg})
            begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo = q_reg;
endmodule
`default_nettype wire

// ----- rtl/core/sample_playback_voice_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sample playback voice: one request in, one result out.
// Every request passes through the loudness divider; when the note span reaches 2^34,
// remaining and total span are halved one shift at a time until the total fits 34 bits.
// The fade ratio is a reciprocal multiply.
// Throughput: one request at a time; next request taken once the result is in the
// output register. Reset clears voice state, resets config; sample RAM is not cleared.
module sample_playback_voice_core #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int RELEASE_FRAMES = 64,
    parameter int FRACTION_BITS = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    spv_in_if.sink   req,
    spv_out_if.source rsp,
    spv_cfg_if.sink  cfg
);
    import spv_pkg::*;

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam logic [POS_W-1:0] FADE_SPAN = POS_W'(RELEASE_FRAMES) << FRACTION_BITS;
    // fade numerator (remaining frames in Q16) is below RELEASE_FRAMES * 2^16
    localparam int FX_W = $clog2(RELEASE_FRAMES) + 16;
    localparam logic [32:0] FADE_RECIP = 33'((64'd1 << 32) / 64'(RELEASE_FRAMES));

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_INTP  = 4'd3;
    localparam logic [3:0] S_GAIN  = 4'd4;
    localparam logic [3:0] S_FDIV  = 4'd5;
    localparam logic [3:0] S_FMUL  = 4'd6;
    localparam logic [3:0] S_MIX   = 4'd7;
    localparam logic [3:0] S_LPREP = 4'd8;
    localparam logic [3:0] S_LSH   = 4'd9;
    localparam logic [3:0] S_LDIV  = 4'd10;
    localparam logic [3:0] S_LWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_FWAIT = 4'd13;
    localparam logic [3:0] S_FFIX  = 4'd14;

    // configuration
    logic [47:0] start_reg, end_reg;
    logic [35:0] step_reg;
    logic [17:0] gain_reg;
    logic [16:0] len_reg;
    logic        fae_reg;

    // voice state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] began_reg, began_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic             fading_reg, fading_next, playing_reg, playing_next;

    logic [3:0]  st_reg, st_next;
    in_item_t    it_reg, it_next;
    logic [AW-1:0] nxt_reg, nxt_next;
    logic signed [15:0] s0_reg, s0_next;
    logic signed [33:0] s_reg, s_next;
    logic [50:0]  mag_reg, mag_next;
    logic [16:0]  fade_reg, fade_next;
    logic [33:0]  q_reg, q_next;
    logic signed [31:0] mix_reg, mix_next;
    logic [POS_W-1:0] rem_reg, rem_next, tot_reg, tot_next;
    out_item_t   o_reg, o_next;
    logic        ov_reg, ov_next;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_ra;
    logic [15:0]   ram_rd;

    spv_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(AW'(it_reg.load_address)),
        .wdata(it_reg.load_value), .raddr(ram_ra), .rdata(ram_rd)
    );

    // loudness divider
    logic        div_start, div_busy;
    logic [52:0] d_num, d_quo;
    logic [34:0] d_den;
    spv_div #(.NW(53), .DW(35)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(d_num), .den(d_den),
        .busy(div_busy), .quo(d_quo)
    );

    // frame index and neighbour
    logic [31:0] valid_n;
    logic [31:0] last_idx;
    logic [POS_W-FRACTION_BITS-1:0] ipart;
    logic [AW-1:0] idx_c, nxt_c;
    always_comb
    begin
        valid_n = (32'(len_reg) > 32'(SAMPLE_DEPTH)) ? 32'(SAMPLE_DEPTH) : 32'(len_reg);
        if (valid_n == '0)
        begin
            valid_n = 32'd1;
        end
        last_idx = valid_n - 32'd1;
        ipart = pos_reg[POS_W-1:FRACTION_BITS];
        if (64'(ipart) > 64'(last_idx))
        begin
            idx_c = AW'(last_idx);
        end
        else
        begin
            idx_c = AW'(ipart);
        end
        nxt_c = (32'(idx_c) + 32'd1 < valid_n) ? idx_c + 1'b1 : idx_c;
    end

    logic [15:0] f16;
    logic [POS_W-1:0] rem_c, fad_rem;
    logic [POS_W:0]   pos_sum, lim_sum;
    logic signed [32:0] mix_sum;
    logic signed [34:0] qs;
    logic [FX_W+32:0] fade_prod;
    logic [FX_W-1:0]  fade_left;
    assign f16 = pos_reg[FRACTION_BITS-1 -: 16];
    assign rem_c = stop_reg - pos_reg;
    // remaining distance with 16 fraction bits; divided by RELEASE_FRAMES below
    assign fad_rem = rem_c >> (FRACTION_BITS - 16);
    // reciprocal estimate is exact or one low; the fix-up step corrects it
    assign fade_prod = (FX_W+33)'(fad_rem[FX_W-1:0]) * (FX_W+33)'(FADE_RECIP);
    assign fade_left = fad_rem[FX_W-1:0] - FX_W'(32'(fade_reg) * 32'(RELEASE_FRAMES));
    assign pos_sum = {1'b0, pos_reg} + (POS_W+1)'(step_reg);
    assign lim_sum = {1'b0, pos_reg} + {1'b0, FADE_SPAN};
    assign qs = s_reg[33] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign mix_sum = 33'(it_reg.mix_in) + 33'(qs);

    always_comb
    begin
        st_next = st_reg;
        it_next = it_reg;
        pos_next = pos_reg;
        began_next = began_reg;
        stop_next = stop_reg;
        fading_next = fading_reg;
        playing_next = playing_reg;
        nxt_next = nxt_reg;
        s0_next = s0_reg;
        s_next = s_reg;
        mag_next = mag_reg;
        fade_next = fade_reg;
        q_next = q_reg;
        mix_next = mix_reg;
        rem_next = rem_reg;
        tot_next = tot_reg;
        o_next = o_reg;
        ov_next = ov_reg;
        ram_we = 1'b0;
        ram_ra = idx_c;
        div_start = 1'b0;
        d_num = '0;
        d_den = '0;
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    it_next = req.data;
                    mix_next = req.data.mix_in;
                    st_next = S_LPREP;
                    case (req.data.opcode)
                        OP_LOAD: ;
                        OP_START:
                        begin
                            playing_next = 1'b0;
                            if (end_reg > start_reg)
                            begin
                                pos_next = POS_W'(start_reg);
                                began_next = POS_W'(start_reg);
                                stop_next = POS_W'(end_reg);
                                fading_next = fae_reg;
                                playing_next = 1'b1;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (playing_reg)
                            begin
                                if (lim_sum[POS_W-1:0] < stop_reg)
                                begin
                                    stop_next = lim_sum[POS_W-1:0];
                                end
                                fading_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (playing_reg)
                            begin
                                if (pos_reg >= stop_reg)
                                begin
                                    playing_next = 1'b0;
                                end
                                else
                                begin
                                    st_next = S_RD0;
                                end
                            end
                        end
                    endcase
                    if (req.data.opcode == OP_LOAD
                        && 32'(req.data.load_address) < 32'(SAMPLE_DEPTH))
                    begin
                        st_next = S_FWAIT;
                    end
                end
            end
            S_FWAIT:
            begin
                ram_we = 1'b1;
                st_next = S_LPREP;
            end
            S_RD0:
            begin
                ram_ra = idx_c;
                nxt_next = nxt_c;
                st_next = S_RD1;
            end
            S_RD1:
            begin
                ram_ra = nxt_reg;
                s0_next = $signed(ram_rd);
                st_next = S_INTP;
            end
            S_INTP:
            begin
                s_next = 34'(s0_reg) * 34'sd65536
                    + 34'(17'($signed(ram_rd)) - 17'(s0_reg)) * $signed({18'd0, f16});
                st_next = S_GAIN;
            end
            S_GAIN:
            begin
                mag_next = 51'(s_reg[33] ? -s_reg : s_reg) * 51'(gain_reg);
                st_next = S_FDIV;
            end
            S_FDIV:
            begin
                fade_next = 17'(fade_prod >> 32);
                st_next = S_FFIX;
            end
            S_FFIX:
            begin
                if (fading_reg && rem_c < FADE_SPAN)
                begin
                    if (fade_left >= FX_W'(RELEASE_FRAMES))
                    begin
                        fade_next = fade_reg + 1'b1;
                    end
                end
                else
                begin
                    fade_next = 17'd65536;
                end
                st_next = S_FMUL;
            end
            S_FMUL:
            begin
                q_next = 34'((51'(mag_reg[50:16]) * 51'(fade_reg)) >> 23);
                st_next = S_MIX;
            end
            S_MIX:
            begin
                if (mix_sum > 33'sd2147483647)
                begin
                    mix_next = 32'sh7fffffff;
                end
                else if (mix_sum < -33'sd2147483648)
                begin
                    mix_next = 32'sh80000000;
                end
                else
                begin
                    mix_next = mix_sum[31:0];
                end
                pos_next = pos_sum[POS_W-1:0];
                if (pos_sum[POS_W-1:0] >= stop_reg)
                begin
                    playing_next = 1'b0;
                end
                st_next = S_LPREP;
            end
            S_LPREP:
            begin
                rem_next = stop_reg - pos_reg;
                tot_next = stop_reg - began_reg;
                st_next = S_LSH;
            end
            S_LSH:
            begin
                // one shift per cycle until total fits 34 bits
                if (tot_reg[POS_W-1:34] != '0)
                begin
                    tot_next = tot_reg >> 1;
                    rem_next = rem_reg >> 1;
                end
                else
                begin
                    st_next = S_LDIV;
                end
            end
            S_LDIV:
            begin
                div_start = 1'b1;
                d_num = 53'(rem_reg[33:0]) * 53'(gain_reg);
                d_den = {1'b0, tot_reg[33:0]};
                st_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (!div_busy)
                begin
                    st_next = S_OUT;
                end
            end
            default:
            begin
                // hold here while the previous result still waits
                if (!ov_reg || rsp.ready)
                begin
                    o_next.mix_out = mix_reg;
                    o_next.voice_active = playing_reg;
                    if (!playing_reg || stop_reg <= began_reg || pos_reg >= stop_reg
                        || tot_reg == '0)
                    begin
                        o_next.loudness = '0;
                    end
                    else
                    begin
                        o_next.loudness = d_quo[17:0];
                    end
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            pos_reg <= '0;
            began_reg <= '0;
            stop_reg <= '0;
            fading_reg <= 1'b0;
            playing_reg <= 1'b0;
            start_reg <= '0;
            end_reg <= '0;
            step_reg <= 36'h100000000;
            gain_reg <= '0;
            len_reg <= 17'd65536;
            fae_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            pos_reg <= pos_next;
            began_reg <= began_next;
            stop_reg <= stop_next;
            fading_reg <= fading_next;
            playing_reg <= playing_next;
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    REG_START:  start_reg <= cfg.data.data[47:0];
                    REG_END:    end_reg <= cfg.data.data[47:0];
                    REG_STEP:   step_reg <= cfg.data.data[35:0];
                    REG_GAIN:   gain_reg <= cfg.data.data[17:0];
                    REG_LENGTH: len_reg <= cfg.data.data[16:0];
                    REG_FADE:   fae_reg <= cfg.data.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        nxt_reg <= nxt_next;
        s0_reg <= s0_next;
        s_reg <= s_next;
        mag_reg <= mag_next;
        fade_reg <= fade_next;
        q_reg <= q_next;
        mix_reg <= mix_next;
        rem_reg <= rem_next;
        tot_reg <= tot_next;
        o_reg <= o_next;
    end

    assign req.ready = (st_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = ov_reg;
    assign rsp.data = o_reg;
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import spv_pkg::*;

    // Voice geometry, matching the core's defaults
    localparam int        FADE_LEN    = 64;
    localparam longint    FRAME_ONE   = 64'd1 << 32;
    localparam int        MEM_DEPTH   = 65536;
    // Frames 0..PREFIX-1 are loaded first; playback never reads beyond them
    localparam int        PREFIX      = 128;
    localparam int        DRAIN_WAIT  = 80;
    localparam int        RANDOM_REQS = 140;

    logic clk;
    logic rst_n;

    spv_in_if  req_ch ();
    spv_out_if rsp_ch ();
    spv_cfg_if cfg_ch ();

    sample_playback_voice_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // ------------------------------------------------------------------
    // Voice predictor: register shadow plus playback state
    // ------------------------------------------------------------------
    logic [47:0]        start_reg, end_reg;
    logic [35:0]        step_reg;
    logic [17:0]        gain_reg;
    logic [16:0]        length_reg;
    logic               fade_reg;
    logic [49:0]        play_pos, stop_pos;
    logic [48:0]        began_pos;
    logic               fading, playing;
    logic signed [15:0] sample_mem [0:MEM_DEPTH-1];

    out_item_t expected_mix[$];
    int        errors;
    int        reqs_sent;
    int        burst_left;
    int        cycle_count;
    int        hold_until;     // receiver holds off while cycle_count < hold_until
    int        ready_pct;

    always #5 clk = ~clk;

    // One interpolated, gained and faded frame at the current position
    function automatic longint frame_value();
        logic [63:0] valid, idx, nxt, f16, rem, mag, fade16, q;
        longint      s0, s1, s;
        logic        neg;
        valid = (length_reg == 0) ? 64'd1 :
                (length_reg > MEM_DEPTH) ? 64'(MEM_DEPTH) : 64'(length_reg);
        idx = 64'(play_pos) >> 32;
        if (idx > valid - 1)
            idx = valid - 1;
        nxt = (idx + 1 < valid) ? idx + 1 : idx;
        f16 = 64'(play_pos[31:16]);
        s0  = longint'(sample_mem[idx]);
        s1  = longint'(sample_mem[nxt]);
        s   = s0 * 65536 + (s1 - s0) * longint'(f16);
        neg = s < 0;
        mag = 64'(neg ? -s : s) * 64'(gain_reg);
        rem = 64'(stop_pos) - 64'(play_pos);
        fade16 = 64'd65536;
        if (fading && rem < 64'(FADE_LEN) * FRAME_ONE)
            fade16 = (rem << 16) / (64'(FADE_LEN) * FRAME_ONE);
        q = ((mag >> 16) * fade16) >> 23;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [17:0] loudness_now();
        logic [63:0] rem, total, ld;
        if (!playing || stop_pos <= 50'(began_pos) || play_pos >= stop_pos)
            return '0;
        rem   = 64'(stop_pos) - 64'(play_pos);
        total = 64'(stop_pos) - 64'(began_pos);
        while (total >= (64'd1 << 34))
        begin
            total = total >> 1;
            rem   = rem >> 1;
        end
        ld = (64'(gain_reg) * rem) / total;
        return ld[17:0];
    endfunction

    function automatic out_item_t voice_result(in_item_t it);
        out_item_t   r;
        longint      mix;
        logic [49:0] lim;
        mix = longint'(it.mix_in);
        case (it.opcode)
            OP_LOAD:
                sample_mem[it.load_address] = it.load_value;
            OP_START:
            begin
                playing = 1'b0;
                if (end_reg > start_reg)
                begin
                    play_pos  = 50'(start_reg);
                    began_pos = 49'(start_reg);
                    stop_pos  = 50'(end_reg);
                    fading    = fade_reg;
                    playing   = 1'b1;
                end
            end
            OP_RELEASE:
                if (playing)
                begin
                    lim = play_pos + 50'(64'(FADE_LEN) * FRAME_ONE);
                    if (lim < stop_pos)
                        stop_pos = lim;
                    fading = 1'b1;
                end
            default:
                if (playing)
                begin
                    if (play_pos >= stop_pos)
                        playing = 1'b0;
                    else
                    begin
                        mix = mix + frame_value();
                        if (mix > 64'sd2147483647)
                            mix = 64'sd2147483647;
                        if (mix < -64'sd2147483648)
                            mix = -64'sd2147483648;
                        play_pos = play_pos + 50'(step_reg);
                        if (play_pos >= stop_pos)
                            playing = 1'b0;
                    end
                end
        endcase
        r.mix_out      = mix[31:0];
        r.voice_active = playing;
        r.loudness     = loudness_now();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compares each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_mix.size() == 0)
            begin
                $display("%0t: unexpected result mix_out=%0d active=%0b loudness=%0d",
                         $time, rsp_ch.data.mix_out, rsp_ch.data.voice_active,
                         rsp_ch.data.loudness);
                errors++;
            end
            else
            begin
                exp_r = expected_mix.pop_front();
                if (rsp_ch.data.mix_out !== exp_r.mix_out)
                begin
                    $display("%0t: mix_out expected %0d actual %0d",
                             $time, exp_r.mix_out, rsp_ch.data.mix_out);
                    errors++;
                end
                if (rsp_ch.data.voice_active !== exp_r.voice_active)
                begin
                    $display("%0t: voice_active expected %0b actual %0b",
                             $time, exp_r.voice_active, rsp_ch.data.voice_active);
                    errors++;
                end
                if (rsp_ch.data.loudness !== exp_r.loudness)
                begin
                    $display("%0t: loudness expected %0d actual %0d",
                             $time, exp_r.loudness, rsp_ch.data.loudness);
                    errors++;
                end
            end
        end
    end

    // Receiver: ready follows a duty cycle that is redrawn at random from four settings, and
    // drops entirely during a hold-off window.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycle_count  <= 0;
            ready_pct    <= 100;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 64 == 0)
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 75;
                    2: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            if (cycle_count < hold_until)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request driver. valid stays up between back-to-back requests; callers
    // that stop sending lower it through wait_idle.
    // ------------------------------------------------------------------
    task automatic send_req(logic [1:0] op, logic [15:0] addr, logic [15:0] value,
                            logic [31:0] mix);
        in_item_t it;
        int       gap;
        it.opcode       = op;
        it.load_address = addr;
        it.load_value   = value;
        it.mix_in       = mix;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_mix.push_back(voice_result(it));
        reqs_sent++;
    endtask

    task automatic send_tick(logic [31:0] mix);
        send_req(OP_TICK, 16'($urandom), 16'($urandom), mix);
    endtask

    // Stop offering requests and let every outstanding result come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        cfg_item_t c;
        c.index = index;
        c.data  = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (index)
            REG_START:  start_reg  = value[47:0];
            REG_END:    end_reg    = value[47:0];
            REG_STEP:   step_reg   = value[35:0];
            REG_GAIN:   gain_reg   = value[17:0];
            REG_LENGTH: length_reg = value[16:0];
            REG_FADE:   fade_reg   = value[0];
            default: ;
        endcase
    endtask

    // Writes all six registers with the voice idle
    task automatic program_voice(logic [47:0] st, logic [47:0] en, logic [35:0] step,
                                 logic [17:0] gain, logic [16:0] len, logic fade);
        wait_idle();
        write_reg(REG_START, 64'(st));
        write_reg(REG_END, 64'(en));
        write_reg(REG_STEP, 64'(step));
        write_reg(REG_GAIN, 64'(gain));
        write_reg(REG_LENGTH, 64'(len));
        write_reg(REG_FADE, 64'(fade));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill the low frames that playback uses, with full-scale words mixed in
    task automatic test_sample_load();
        logic [15:0] v;
        for (int i = 0; i < PREFIX; i++)
        begin
            case (i % 8)
                0: v = 16'h7fff;
                1: v = 16'h8000;
                2: v = 16'h0000;
                default: v = 16'($urandom);
            endcase
            send_req(OP_LOAD, 16'(i), v, 32'($urandom));
        end
        // top address, never played back
        send_req(OP_LOAD, 16'hffff, 16'h5a5a, 32'h8000_0000);
    endtask

    // Release and tick while idle, and starts with an empty or reversed range
    task automatic test_idle_requests();
        send_req(OP_RELEASE, 16'h0, 16'h0, 32'h7fff_ffff);
        send_tick(32'h8000_0000);
        program_voice(48'd5 << 32, 48'd5 << 32, 36'd1 << 32, 18'd65536, 17'd128, 1'b0);
        send_req(OP_START, 16'h0, 16'h0, 32'h1234_5678);
        send_tick(32'h0);
        program_voice(48'd9 << 32, 48'd3 << 32, 36'd1 << 32, 18'd65536, 17'd128, 1'b1);
        send_req(OP_START, 16'h0, 16'h0, 32'h0);
        send_tick(32'h0);
    endtask

    // Fractional play with fade, release, saturating mix bus, run past the end
    task automatic test_basic_playback();
        program_voice((48'd2 << 32) | 48'h8000_0000, 48'd20 << 32, 36'h1_4000_0000,
                      18'd65536, 17'd128, 1'b1);
        send_req(OP_START, 16'h0, 16'h0, 32'h0);
        send_tick(32'h7fff_ffff);
        send_tick(32'h8000_0000);
        send_tick(32'h0);
        send_req(OP_RELEASE, 16'h0, 16'h0, 32'h0100_0000);
        for (int i = 0; i < 16; i++)
            send_tick(32'($urandom));
    endtask

    // Register extremes: gain, step, length, start and end at their limits
    task automatic test_register_extremes();
        for (int k = 0; k < 7; k++)
        begin
            case (k)
                0: program_voice(48'd0, 48'd30 << 32, 36'hf_ffff_ffff, 18'd131072,
                                 17'd128, 1'b0);
                1: program_voice(48'd1 << 32, 48'd12 << 32, 36'd0, 18'd0, 17'd1, 1'b1);
                2: program_voice(48'd3 << 32, 48'd90 << 32, 36'h0_8000_0001, 18'd131072,
                                 17'd65536, 1'b1);
                3: program_voice(48'hffff_0000_0000, 48'hffff_ffff_ffff, 36'h1_0000_0000,
                                 18'd131072, 17'd100, 1'b1);
                4: program_voice(48'hffff_ffff_fffe, 48'hffff_ffff_ffff, 36'd1, 18'd65535,
                                 17'd128, 1'b0);
                5: program_voice(48'd0, 48'd1, 36'd1, 18'd131072, 17'd2, 1'b1);
                default: program_voice(48'd0, 48'hffff_ffff_ffff, 36'h8_0000_0000,
                                       18'd1, 17'd128, 1'b1);
            endcase
            send_req(OP_START, 16'h0, 16'h0, 32'h0);
            for (int i = 0; i < 8; i++)
                send_tick(i[0] ? 32'h7fff_ffff : 32'h8000_0000);
            send_req(OP_RELEASE, 16'h0, 16'h0, 32'h0);
            for (int i = 0; i < 3; i++)
                send_tick(32'($urandom));
        end
    endtask

    // Mostly well-formed note sequences with random content, some noise
    task automatic test_random_notes();
        logic [47:0] st, span;
        logic [35:0] step;
        logic [16:0] len;
        int          n, rel_at;
        while (reqs_sent < RANDOM_REQS + PREFIX + 100)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: random requests against whatever was programmed last
                for (int i = 0; i < 6; i++)
                    send_req(2'($urandom), 16'($urandom), 16'($urandom), 32'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        // full-length sample; keep the range inside loaded frames
                        len = 17'd65536;
                        st  = (48'($urandom_range(0, 60)) << 32) | 48'($urandom);
                        span = (48'($urandom_range(0, 34)) << 32) | 48'($urandom);
                    end
                    1:
                    begin
                        // far position; reads clamp to the last valid frame
                        len = 17'($urandom_range(1, PREFIX));
                        st  = {16'($urandom), 32'($urandom)};
                        span = (48'($urandom_range(0, 40)) << 32) | 48'($urandom);
                    end
                    default:
                    begin
                        len = 17'($urandom_range(1, PREFIX));
                        st  = (48'($urandom_range(0, PREFIX + 8)) << 32) | 48'($urandom);
                        span = (48'($urandom_range(0, 40)) << 32) | 48'($urandom);
                    end
                endcase
                if (span == 0)
                    span = 48'd1;
                if (st > 48'hffff_ffff_ffff - span)
                    st = 48'hffff_ffff_ffff - span;
                step = ($urandom_range(0, 5) == 0) ? {4'($urandom), 32'($urandom)}
                                                   : 36'($urandom_range(1, 12)) << 30
                                                     | 36'($urandom_range(0, 65535));
                program_voice(st, st + span, step, 18'($urandom_range(0, 131072)), len,
                              1'($urandom));
                n      = $urandom_range(2, 30);
                rel_at = $urandom_range(0, n + 5);
                send_req(OP_START, 16'($urandom), 16'($urandom), 32'($urandom));
                for (int i = 0; i < n; i++)
                begin
                    if (i == rel_at)
                        send_req(OP_RELEASE, 16'($urandom), 16'($urandom), 32'($urandom));
                    else if ($urandom_range(0, 19) == 0)
                        send_req(OP_LOAD, 16'($urandom_range(0, PREFIX - 1)),
                                 16'($urandom), 32'($urandom));
                    else
                        send_tick(32'($urandom));
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        program_voice(48'd1 << 32, 48'd100 << 32, 36'h0_c000_0000, 18'd98304, 17'd128,
                      1'b1);
        hold_until = cycle_count + 400;
        send_req(OP_START, 16'h0, 16'h0, 32'h0);
        for (int i = 0; i < 20; i++)
            send_tick(32'($urandom));
        send_req(OP_RELEASE, 16'h0, 16'h0, 32'h0);
        for (int i = 0; i < 10; i++)
            send_tick(32'($urandom));
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        errors       = 0;
        reqs_sent    = 0;
        burst_left   = 0;
        hold_until   = 0;
        // register defaults after reset
        start_reg  = '0;
        end_reg    = '0;
        step_reg   = 36'h1_0000_0000;
        gain_reg   = '0;
        length_reg = 17'd65536;
        fade_reg   = 1'b0;
        play_pos   = '0;
        began_pos  = '0;
        stop_pos   = '0;
        fading     = 1'b0;
        playing    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_sample_load();
        test_idle_requests();
        test_basic_playback();
        test_register_extremes();
        test_random_notes();
        test_output_backpressure();

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
